[rtl/fjed_pkg.sv]
// ============================================================================
// fjed_pkg
// Shared types and constants of the frame jitter event detector.
// ============================================================================
package fjed_pkg;

  // Width of every frame time value (unsigned, 8 fraction bits, milliseconds)
  localparam int unsigned TIME_W = 20;

  // Largest value that fits a time field
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Peak frame time above which a slow event is blamed on IO (50 ms)
  localparam logic [TIME_W-1:0] IO_LIMIT = 20'd12800;

  // Largest severity value
  localparam logic [6:0] SEVERITY_MAX = 7'd100;

  // Reset values of the configuration registers
  localparam logic [TIME_W-1:0] JITTER_THR_RESET = 20'd512;
  localparam logic [TIME_W-1:0] SPIKE_THR_RESET  = 20'd2048;
  localparam logic [TIME_W-1:0] CPU_LIMIT_RESET  = 20'd4267;
  localparam logic [TIME_W-1:0] GPU_LIMIT_RESET  = 20'd4267;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_JITTER_THR = 2'd0,
    CFG_SPIKE_THR  = 2'd1,
    CFG_CPU_LIMIT  = 2'd2,
    CFG_GPU_LIMIT  = 2'd3
  } cfg_reg_t;

  // Cause codes of a closed event
  typedef enum logic [1:0] {
    CAUSE_UNKNOWN = 2'd0,
    CAUSE_CPU     = 2'd1,
    CAUSE_GPU     = 2'd2,
    CAUSE_IO      = 2'd3
  } cause_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WALK,
    S_MUL,
    S_CAUSE,
    S_EMIT
  } state_t;

  // One ring entry: CPU and GPU time of one frame
  typedef struct packed {
    logic [TIME_W-1:0] cpu;
    logic [TIME_W-1:0] gpu;
  } ring_entry_t;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/fjed_ring.sv]
// ============================================================================
// fjed_ring
// Ring memory of per-frame CPU and GPU times: one write port and one read
// port with registered read data.
// ============================================================================
module fjed_ring #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  fjed_pkg::ring_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output fjed_pkg::ring_entry_t rd_data
);

  fjed_pkg::ring_entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

[rtl/fjed_div.sv]
// ============================================================================
// fjed_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per
// cycle.
// ============================================================================
module fjed_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [15:0]         divisor,
  output fjed_pkg::div_status_t status,
  output logic [31:0]         quotient
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  bit_cnt;
  logic        busy;
  logic [16:0] trial;
  logic        take;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, quotient[31]};
    take  = (trial >= {1'b0, dvs});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 5'd1;
      if (bit_cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: the quotient register shifts the dividend out as it fills.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quotient <= {quotient[30:0], take};
    end
  end

  assign status.busy = busy;
  assign status.done = !busy;

endmodule

[rtl/frame_jitter_event_detector.sv]
// ============================================================================
// frame_jitter_event_detector
// Frame jitter event detector: tracks jitter spikes between frames, opens an
// event at two spikes and reports it, with its cause, when it calms down.
// ============================================================================
// Sequence: a frame that closes no event is accepted in S_IDLE and updated in S_STEP.
// A frame that closes an event then walks the ring (one entry per cycle), passes S_MUL and
//   S_CAUSE, and loads its report in S_EMIT once the 32-step divider is done.
// Throughput: one frame at a time; in_stall stays high while a frame works.
// Reset: synchronous; clears all event state, the ring fill count and loads
//   the default thresholds; the ring memory itself is not cleared.
module frame_jitter_event_detector #(
  parameter int unsigned WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  // input frames
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] frame_time,
  input  logic [19:0] cpu_time,
  input  logic [19:0] gpu_time,
  // closed events
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] first_frame,
  output logic [15:0] frame_count,
  output logic [19:0] peak_time,
  output logic [19:0] mean_jitter,
  output logic [6:0]  severity,
  output logic [1:0]  cause
);

  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = fjed_pkg::TIME_W + FILL_W;

  // Configuration registers
  logic [19:0] jitter_threshold;
  logic [19:0] spike_threshold;
  logic [19:0] cpu_limit;
  logic [19:0] gpu_limit;

  // Sequencer
  fjed_pkg::state_t state, state_next;

  // Captured input beat
  logic [19:0] ft_q, ct_q, gt_q;

  // Detector state
  logic [19:0] prev_time;
  logic        have_prev;
  logic        event_open,   event_open_next;
  logic [15:0] spike_tally,  spike_tally_next;
  logic [31:0] jitter_total, jitter_total_next;
  logic [31:0] event_begin,  event_begin_next;
  logic [31:0] event_finish, event_finish_next;
  logic [19:0] event_peak,   event_peak_next;
  logic [31:0] frame_number;
  logic [IDX_W-1:0]  ring_pos;
  logic [FILL_W-1:0] ring_fill;

  // Step datapath
  logic [19:0] jit;
  logic [32:0] jt_add;
  logic [31:0] fn_new;
  logic [15:0] tally_inc, tally_dec;
  logic        open_now;
  logic [19:0] peak_base;
  logic        step_close;
  logic [31:0] span_c;
  logic [15:0] cnt_c;

  // Event snapshot
  logic [31:0] snap_begin;
  logic [31:0] snap_span;
  logic [15:0] snap_cnt;
  logic [31:0] snap_jt;
  logic [19:0] snap_peak;

  // Ring walk
  logic [FILL_W-1:0] walk_k;
  logic [IDX_W-1:0]  walk_idx;
  logic [31:0]       walk_frame;
  logic              walk_issue;
  logic              walk_incl;
  logic              rd_pend;
  logic              rd_inc;
  logic [SUM_W-1:0]  cpu_sum, gpu_sum;
  logic [FILL_W-1:0] walk_n;
  logic [SUM_W-1:0]  cpu_prod, gpu_prod;
  fjed_pkg::cause_t  cause_q;

  // Control outputs
  logic step_en;
  logic close_fire;
  logic emit_load;

  // Ring and divider connections
  fjed_pkg::ring_entry_t ring_wr, ring_rd;
  fjed_pkg::div_status_t div_st;
  logic [31:0] div_q;
  logic [15:0] divisor;

  // Severity
  logic [36:0] sev_full;

  // --------------------------------------------------------------------------
  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_threshold <= fjed_pkg::JITTER_THR_RESET;
      spike_threshold  <= fjed_pkg::SPIKE_THR_RESET;
      cpu_limit        <= fjed_pkg::CPU_LIMIT_RESET;
      gpu_limit        <= fjed_pkg::GPU_LIMIT_RESET;
    end else if (cfg_write) begin
      case (fjed_pkg::cfg_reg_t'(cfg_index))
        fjed_pkg::CFG_JITTER_THR: jitter_threshold <= cfg_data;
        fjed_pkg::CFG_SPIKE_THR:  spike_threshold  <= cfg_data;
        fjed_pkg::CFG_CPU_LIMIT:  cpu_limit        <= cfg_data;
        fjed_pkg::CFG_GPU_LIMIT:  gpu_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      fjed_pkg::S_IDLE: begin
        if (in_valid) state_next = fjed_pkg::S_STEP;
      end
      fjed_pkg::S_STEP: begin
        state_next = step_close ? fjed_pkg::S_WALK : fjed_pkg::S_IDLE;
      end
      fjed_pkg::S_WALK: begin
        if (walk_k == ring_fill && !rd_pend) state_next = fjed_pkg::S_MUL;
      end
      fjed_pkg::S_MUL:   state_next = fjed_pkg::S_CAUSE;
      fjed_pkg::S_CAUSE: state_next = fjed_pkg::S_EMIT;
      fjed_pkg::S_EMIT: begin
        if (emit_load) state_next = fjed_pkg::S_IDLE;
      end
      default: state_next = fjed_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = (state != fjed_pkg::S_IDLE);
    step_en    = (state == fjed_pkg::S_STEP);
    close_fire = step_en && step_close;
    walk_issue = (state == fjed_pkg::S_WALK) && (walk_k != ring_fill);
    emit_load  = (state == fjed_pkg::S_EMIT) && div_st.done && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fjed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ft_q <= frame_time;
      ct_q <= cpu_time;
      gt_q <= gpu_time;
    end
  end

  // --------------------------------------------------------------------------
  // Per-frame update of the jitter sum, spike tally and event bounds.
  always_comb begin
    jit       = (ft_q > prev_time) ? ft_q - prev_time : prev_time - ft_q;
    jt_add    = {1'b0, jitter_total} + 33'(jit);
    fn_new    = frame_number + 32'd1;
    tally_inc = (spike_tally == 16'hFFFF) ? spike_tally : spike_tally + 16'd1;
    tally_dec = (spike_tally != 16'd0) ? spike_tally - 16'd1 : 16'd0;
    span_c    = event_finish - event_begin;
    cnt_c     = (span_c[31:16] != 16'd0) ? 16'hFFFF : span_c[15:0];

    event_open_next   = event_open;
    spike_tally_next  = spike_tally;
    jitter_total_next = jitter_total;
    event_begin_next  = event_begin;
    event_finish_next = event_finish;
    event_peak_next   = event_peak;
    open_now          = event_open;
    peak_base         = event_peak;
    step_close        = 1'b0;

    if (have_prev) begin
      if (jit > jitter_threshold) begin
        jitter_total_next = jt_add[32] ? 32'hFFFF_FFFF : jt_add[31:0];
        if (jit > spike_threshold) begin
          spike_tally_next = tally_inc;
          if (!event_open && tally_inc >= 16'd2) begin
            open_now         = 1'b1;
            event_begin_next = fn_new - 32'(tally_inc);
            peak_base        = '0;
          end
          if (open_now) begin
            event_open_next   = 1'b1;
            event_finish_next = fn_new;
            event_peak_next   = (ft_q > peak_base) ? ft_q : peak_base;
          end
        end
      end else if (event_open) begin
        spike_tally_next = tally_dec;
        if (tally_dec == 16'd0) begin
          step_close        = 1'b1;
          event_open_next   = 1'b0;
          jitter_total_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time    <= '0;
      have_prev    <= 1'b0;
      event_open   <= 1'b0;
      spike_tally  <= '0;
      jitter_total <= '0;
      event_begin  <= '0;
      event_finish <= '0;
      event_peak   <= '0;
      frame_number <= '0;
      ring_pos     <= '0;
      ring_fill    <= '0;
    end else if (step_en) begin
      prev_time    <= ft_q;
      have_prev    <= 1'b1;
      event_open   <= event_open_next;
      spike_tally  <= spike_tally_next;
      jitter_total <= jitter_total_next;
      event_begin  <= event_begin_next;
      event_finish <= event_finish_next;
      event_peak   <= event_peak_next;
      frame_number <= fn_new;
      ring_pos     <= (ring_pos == IDX_W'(WINDOW - 1)) ? '0 : ring_pos + IDX_W'(1);
      if (ring_fill != FILL_W'(WINDOW)) begin
        ring_fill <= ring_fill + FILL_W'(1);
      end
    end
  end

  // Snapshot of the closing event.
  always_ff @(posedge clk) begin
    if (close_fire) begin
      snap_begin <= event_begin;
      snap_span  <= span_c;
      snap_cnt   <= cnt_c;
      snap_jt    <= jitter_total;
      snap_peak  <= event_peak;
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory: every frame writes its CPU and GPU time.
  assign ring_wr.cpu = ct_q;
  assign ring_wr.gpu = gt_q;

  fjed_ring #(
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (step_en),
    .wr_idx  (ring_pos),
    .wr_data (ring_wr),
    .rd_en   (walk_issue),
    .rd_idx  (walk_idx),
    .rd_data (ring_rd)
  );

  // Walk the ring from the newest entry back, summing the event's frames.
  assign walk_incl = ((walk_frame - snap_begin) < snap_span);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (close_fire) begin
      walk_k     <= '0;
      walk_idx   <= ring_pos;
      walk_frame <= frame_number;
      walk_n     <= '0;
      cpu_sum    <= '0;
      gpu_sum    <= '0;
    end else begin
      if (walk_issue) begin
        walk_k     <= walk_k + FILL_W'(1);
        walk_idx   <= (walk_idx == '0) ? IDX_W'(WINDOW - 1) : walk_idx - IDX_W'(1);
        walk_frame <= walk_frame - 32'd1;
        rd_inc     <= walk_incl;
      end
      if (rd_pend && rd_inc) begin
        cpu_sum <= cpu_sum + SUM_W'(ring_rd.cpu);
        gpu_sum <= gpu_sum + SUM_W'(ring_rd.gpu);
        walk_n  <= walk_n + FILL_W'(1);
      end
    end
  end

  // Limits scaled by the number of summed frames.
  always_ff @(posedge clk) begin
    if (state == fjed_pkg::S_MUL) begin
      cpu_prod <= SUM_W'(cpu_limit) * SUM_W'(walk_n);
      gpu_prod <= SUM_W'(gpu_limit) * SUM_W'(walk_n);
    end
  end

  // Cause decision.
  always_ff @(posedge clk) begin
    if (state == fjed_pkg::S_CAUSE) begin
      if (walk_n == '0) begin
        cause_q <= fjed_pkg::CAUSE_UNKNOWN;
      end else if (cpu_sum > cpu_prod && cpu_sum > gpu_sum) begin
        cause_q <= fjed_pkg::CAUSE_CPU;
      end else if (gpu_sum > gpu_prod) begin
        cause_q <= fjed_pkg::CAUSE_GPU;
      end else if (snap_peak > fjed_pkg::IO_LIMIT) begin
        cause_q <= fjed_pkg::CAUSE_IO;
      end else begin
        cause_q <= fjed_pkg::CAUSE_UNKNOWN;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Mean jitter divider, started as the event closes.
  assign divisor = (cnt_c != 16'd0) ? cnt_c : 16'd1;

  fjed_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (close_fire),
    .dividend (jitter_total),
    .divisor  (divisor),
    .status   (div_st),
    .quotient (div_q)
  );

  // Severity: jitter sum times ten plus count times 512, scaled down by 256.
  assign sev_full = ({5'd0, snap_jt} << 3) + ({5'd0, snap_jt} << 1)
                  + (37'(snap_cnt) << 9);

  // --------------------------------------------------------------------------
  // Output register; the next frame may enter while a beat waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      first_frame <= snap_begin;
      frame_count <= snap_cnt;
      peak_time   <= snap_peak;
      mean_jitter <= (div_q[31:20] != 12'd0) ? fjed_pkg::TIME_MAX : div_q[19:0];
      severity    <= (sev_full[36:8] > 29'(fjed_pkg::SEVERITY_MAX))
                     ? fjed_pkg::SEVERITY_MAX : sev_full[14:8];
      cause       <= cause_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(WINDOW))
    else $error("ring fill count exceeds the window");

  a_open_tally: assert property (@(posedge clk) disable iff (rst)
    event_open |-> spike_tally != 16'd0)
    else $error("open event with an empty spike tally");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    close_fire |=> !event_open && spike_tally == 16'd0 && jitter_total == 32'd0)
    else $error("event close did not clear the event state");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == fjed_pkg::S_WALK)
    else $error("ring read returned outside the walk");

  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> !div_st.busy && walk_n <= walk_k)
    else $error("result loaded before the divider or walk finished");

endmodule
